// ===== design/dq_pkg.sv =====
// Shared constants and types for the double-ended queue.
package dq_pkg;

  localparam int DEPTH  = 32;
  localparam int DATA_W = 32;
  localparam int CAP_W  = 6;
  localparam int OCC_W  = 6;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(32);

  typedef enum logic [1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_REAR  = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_REAR   = 2'd3
  } dq_op_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } dq_status_t;

  typedef struct packed {
    logic push_front;
    logic push_rear;
    logic pop_front;
    logic pop_rear;
  } dq_cmd_t;

endpackage

// ===== design/double_ended_queue_top.sv =====
// Top level of the double-ended queue: request handshake, capacity check and cell chain.
//
// Bounded deque of signed 32-bit items held in a row of 32 cells, the front item in the
// first cell. Every request (insert front, insert rear, remove front, remove rear) acts
// at the clock edge that accepts it: the whole chain shifts or one cell updates, and the
// result appears in the output register on the next cycle. With the output taken every
// cycle the block accepts one request per cycle; a refused request leaves the contents
// unchanged and reports full or empty. Capacity is written through cfg_wr_en and
// cfg_wr_data, by the user only while no request is in flight (unchecked). Values above
// 32 act as 32, zero refuses all inserts. Reset empties the deque and sets capacity to 32.
module double_ended_queue_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        operation,
  input  logic signed [dq_pkg::DATA_W-1:0]  value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        status,
  output logic signed [dq_pkg::DATA_W-1:0]  removed_value,
  output logic [dq_pkg::OCC_W-1:0]          occupancy,
  input  logic                              cfg_wr_en,
  input  logic [dq_pkg::CAP_W-1:0]          cfg_wr_data
);

  logic [dq_pkg::CAP_W-1:0]  capacity;
  logic [dq_pkg::CNT_W-1:0]  count;
  logic [dq_pkg::CNT_W-1:0]  count_next;
  logic                      accept;
  logic                      is_full;
  logic                      is_empty;
  logic [dq_pkg::CMP_W-1:0]  cap_ext;
  logic [dq_pkg::CMP_W-1:0]  eff_cap;
  dq_pkg::dq_cmd_t           cmd;
  dq_pkg::dq_status_t        result_status;
  logic [dq_pkg::DATA_W-1:0] result_value;
  logic [dq_pkg::DATA_W-1:0] rear_value;

  logic [dq_pkg::DATA_W-1:0] cell_data  [dq_pkg::DEPTH];
  logic                      cell_valid [dq_pkg::DEPTH];
  logic [dq_pkg::DATA_W-1:0] cell_tail  [dq_pkg::DEPTH];

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  assign cap_ext  = dq_pkg::CMP_W'(capacity);
  assign eff_cap  = (cap_ext > dq_pkg::CMP_W'(dq_pkg::DEPTH)) ?
                    dq_pkg::CMP_W'(dq_pkg::DEPTH) : cap_ext;
  assign is_full  = dq_pkg::CMP_W'(count) >= eff_cap;
  assign is_empty = (count == '0);

  always_comb begin
    cmd           = '0;
    result_status = dq_pkg::ST_DONE;
    result_value  = '0;
    count_next    = count;
    unique case (dq_pkg::dq_op_t'(operation))
      dq_pkg::OP_PUSH_FRONT, dq_pkg::OP_PUSH_REAR: begin
        if (is_full) begin
          result_status = dq_pkg::ST_FULL;
        end else begin
          cmd.push_front = (dq_pkg::dq_op_t'(operation) == dq_pkg::OP_PUSH_FRONT);
          cmd.push_rear  = (dq_pkg::dq_op_t'(operation) == dq_pkg::OP_PUSH_REAR);
          count_next     = count + dq_pkg::CNT_W'(1);
        end
      end
      dq_pkg::OP_POP_FRONT: begin
        if (is_empty) begin
          result_status = dq_pkg::ST_EMPTY;
        end else begin
          cmd.pop_front = 1'b1;
          result_value  = cell_data[0];
          count_next    = count - dq_pkg::CNT_W'(1);
        end
      end
      dq_pkg::OP_POP_REAR: begin
        if (is_empty) begin
          result_status = dq_pkg::ST_EMPTY;
        end else begin
          cmd.pop_rear = 1'b1;
          result_value = rear_value;
          count_next   = count - dq_pkg::CNT_W'(1);
        end
      end
      default: begin
        cmd = '0;
      end
    endcase
    if (!accept) begin
      cmd = '0;
    end
  end

  always_comb begin
    rear_value = '0;
    for (int i = 0; i < dq_pkg::DEPTH; i++) begin
      rear_value = rear_value | cell_tail[i];
    end
  end

  for (genvar i = 0; i < dq_pkg::DEPTH; i++) begin : g_cell
    logic [dq_pkg::DATA_W-1:0] left_data;
    logic                      left_valid;
    logic [dq_pkg::DATA_W-1:0] right_data;
    logic                      right_valid;

    if (i == 0) begin : g_first
      assign left_data  = value;
      assign left_valid = 1'b1;
    end else begin : g_inner_left
      assign left_data  = cell_data[i-1];
      assign left_valid = cell_valid[i-1];
    end

    if (i == dq_pkg::DEPTH - 1) begin : g_last
      assign right_data  = '0;
      assign right_valid = 1'b0;
    end else begin : g_inner_right
      assign right_data  = cell_data[i+1];
      assign right_valid = cell_valid[i+1];
    end

    dq_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .cmd         (cmd),
      .new_value   (value),
      .left_data   (left_data),
      .left_valid  (left_valid),
      .right_data  (right_data),
      .right_valid (right_valid),
      .data        (cell_data[i]),
      .valid       (cell_valid[i]),
      .tail_data   (cell_tail[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= dq_pkg::CAP_RESET;
    end else if (cfg_wr_en) begin
      capacity <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status        <= result_status;
      removed_value <= result_value;
      occupancy     <= dq_pkg::OCC_W'(count_next);
    end
  end

endmodule

// ===== design/dq_cell.sv =====
// One storage cell of the deque chain: holds one entry and shifts with its neighbors.
module dq_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  dq_pkg::dq_cmd_t             cmd,
  input  logic [dq_pkg::DATA_W-1:0]   new_value,
  input  logic [dq_pkg::DATA_W-1:0]   left_data,
  input  logic                        left_valid,
  input  logic [dq_pkg::DATA_W-1:0]   right_data,
  input  logic                        right_valid,
  output logic [dq_pkg::DATA_W-1:0]   data,
  output logic                        valid,
  output logic [dq_pkg::DATA_W-1:0]   tail_data
);

  logic tail;

  assign tail      = valid && !right_valid;
  assign tail_data = tail ? data : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (cmd.push_front) begin
      valid <= left_valid;
    end else if (cmd.push_rear) begin
      if (!valid && left_valid) begin
        valid <= 1'b1;
      end
    end else if (cmd.pop_front) begin
      valid <= right_valid;
    end else if (cmd.pop_rear) begin
      if (tail) begin
        valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push_front) begin
      data <= left_data;
    end else if (cmd.push_rear && !valid && left_valid) begin
      data <= new_value;
    end else if (cmd.pop_front) begin
      data <= right_data;
    end
  end

endmodule
